// ----- src/blws_pkg.sv -----
// ----------------------------------------------------------------------------
// blws_pkg
// Shared types and constants for the binary-lifting walk-sum engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package blws_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int LEVELS      = 60;
  localparam int WEIGHT_BITS = 32;
  localparam int SUM_BITS    = 64;

  localparam int NODE_BITS       = $clog2(MAX_NODES);
  localparam int NODE_COUNT_BITS = NODE_BITS + 1;
  localparam int LEVEL_BITS      = $clog2(LEVELS + 1);
  localparam int STEP_BITS       = 60;
  localparam int ACTION_BITS     = 2;
  localparam int STATUS_BITS     = 2;
  localparam int ADDR_BITS       = LEVEL_BITS + NODE_BITS;
  localparam int MEM_DEPTH       = LEVELS * MAX_NODES;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = NODE_COUNT_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_NODE_COUNT  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LEVEL_COUNT = 2'd1;

  localparam logic [ACTION_BITS-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_BUILD = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_QUERY = 2'd2;

  localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_STEPS = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic [ACTION_BITS-1:0]        action;
    logic [NODE_BITS-1:0]          node;
    logic [NODE_BITS-1:0]          next_node;
    logic signed [WEIGHT_BITS-1:0] weight;
    logic [STEP_BITS-1:0]          steps;
  } item_t;

  typedef struct packed {
    logic [NODE_BITS-1:0]       end_node;
    logic signed [SUM_BITS-1:0] total;
    logic [STATUS_BITS-1:0]     status;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_BUILD_RD0,
    S_BUILD_RD1,
    S_BUILD_WR,
    S_QUERY,
    S_QSTEP,
    S_QACC,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

// ----- src/binary_lifting_walk_sum.sv -----
// ----------------------------------------------------------------------------
// binary_lifting_walk_sum
// Jump and sum tables over a functional graph, with load, build and query.
// ----------------------------------------------------------------------------
// One item is worked at a time and every item returns one result. A load
// writes one level-0 entry when both nodes are in range, then returns. A
// build walks each node of each new level in turn, since each node of each new
// level needs two reads and one write of the tables. A query steps through
// the levels in order, with one more step per set bit of steps for the table
// read. The tables are two memories, each with one read port and one write
// port, and the single read per cycle is what paces builds and queries.
// Tables are not cleared at reset; every entry must be loaded and built
// before it is queried.
`timescale 1ns / 1ps
`default_nettype none

module binary_lifting_walk_sum (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [blws_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [blws_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                             item_valid,
  output logic                                  item_stall,
  input  wire blws_pkg::item_t                  item,
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output blws_pkg::result_t                     result
);
  import blws_pkg::*;

  state_t state;
  state_t state_next;

  logic [NODE_COUNT_BITS-1:0] node_count;
  logic [LEVEL_BITS-1:0]      level_count;

  item_t   item_q;
  result_t res;

  logic [LEVEL_BITS-1:0] b_level;
  logic [NODE_BITS-1:0]  b_node;
  logic [SUM_BITS-1:0]   b_sum;

  logic [LEVEL_BITS-1:0] q_level;
  logic [NODE_BITS-1:0]  cur;
  logic [SUM_BITS-1:0]   acc;

  logic [NODE_BITS-1:0] jump_mem [0:MEM_DEPTH-1];
  logic [SUM_BITS-1:0]  sum_mem  [0:MEM_DEPTH-1];
  logic [NODE_BITS-1:0] jump_rd;
  logic [SUM_BITS-1:0]  sum_rd;

  logic                 rd_en;
  logic [ADDR_BITS-1:0] rd_addr;
  logic                 wr_en;
  logic [ADDR_BITS-1:0] wr_addr;
  logic [NODE_BITS-1:0] wr_jump;
  logic [SUM_BITS-1:0]  wr_sum;

  logic accept;
  logic out_free;
  logic node_ok;
  logic next_ok;
  logic steps_over;
  logic build_done;
  logic build_last_node;
  logic q_done;
  logic q_bit;

  logic [NODE_COUNT_BITS-1:0] cfg_nodes;
  logic [LEVEL_BITS-1:0]      cfg_levels;

  assign accept   = item_valid && !item_stall;
  assign out_free = !result_valid || !result_stall;

  assign node_ok    = {1'b0, item_q.node} < node_count;
  assign next_ok    = {1'b0, item_q.next_node} < node_count;
  assign steps_over = |(item_q.steps >> level_count);

  assign build_done      = ({1'b0, b_level} + (LEVEL_BITS + 1)'(1)) >= {1'b0, level_count};
  assign build_last_node = ({1'b0, b_node} + NODE_COUNT_BITS'(1)) >= node_count;

  assign q_done = q_level == level_count;
  assign q_bit  = (q_level < LEVEL_BITS'(LEVELS)) && item_q.steps[q_level];

  // Configuration writes are clamped to the legal range of each register.
  always_comb begin
    cfg_nodes = cfg_data;
    if (cfg_nodes == '0) begin
      cfg_nodes = NODE_COUNT_BITS'(1);
    end else if (cfg_nodes > NODE_COUNT_BITS'(MAX_NODES)) begin
      cfg_nodes = NODE_COUNT_BITS'(MAX_NODES);
    end
    cfg_levels = cfg_data[LEVEL_BITS-1:0];
    if (cfg_levels == '0) begin
      cfg_levels = LEVEL_BITS'(1);
    end else if (cfg_levels > LEVEL_BITS'(LEVELS)) begin
      cfg_levels = LEVEL_BITS'(LEVELS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= NODE_COUNT_BITS'(MAX_NODES);
      level_count <= LEVEL_BITS'(LEVELS);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_NODE_COUNT:  node_count  <= cfg_nodes;
        CFG_LEVEL_COUNT: level_count <= cfg_levels;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (item.action)
            ACT_LOAD:  state_next = S_LOAD;
            ACT_BUILD: state_next = S_BUILD_RD0;
            ACT_QUERY: state_next = S_QUERY;
            default:   state_next = S_RESP;
          endcase
        end
      end
      S_LOAD:      state_next = S_RESP;
      S_BUILD_RD0: state_next = build_done ? S_RESP : S_BUILD_RD1;
      S_BUILD_RD1: state_next = S_BUILD_WR;
      S_BUILD_WR:  state_next = S_BUILD_RD0;
      S_QUERY:     state_next = (!node_ok || steps_over) ? S_RESP : S_QSTEP;
      S_QSTEP: begin
        if (q_done) begin
          state_next = S_RESP;
        end else if (q_bit) begin
          state_next = S_QACC;
        end
      end
      S_QACC: state_next = S_QSTEP;
      S_RESP: state_next = out_free ? S_IDLE : S_RESP;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    item_stall = state != S_IDLE;
    rd_en      = 1'b0;
    rd_addr    = {b_level, b_node};
    wr_en      = 1'b0;
    wr_addr    = {b_level + LEVEL_BITS'(1), b_node};
    wr_jump    = jump_rd;
    wr_sum     = b_sum + sum_rd;
    case (state)
      S_LOAD: begin
        wr_en   = node_ok && next_ok;
        wr_addr = {LEVEL_BITS'(0), item_q.node};
        wr_jump = item_q.next_node;
        wr_sum  = SUM_BITS'(item_q.weight);
      end
      S_BUILD_RD0: begin
        rd_en = !build_done;
      end
      S_BUILD_RD1: begin
        rd_en   = 1'b1;
        rd_addr = {b_level, jump_rd};
      end
      S_BUILD_WR: begin
        wr_en = 1'b1;
      end
      S_QSTEP: begin
        rd_en   = !q_done && q_bit;
        rd_addr = {q_level, cur};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      jump_mem[wr_addr] <= wr_jump;
      sum_mem[wr_addr]  <= wr_sum;
    end
    if (rd_en) begin
      jump_rd <= jump_mem[rd_addr];
      sum_rd  <= sum_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          item_q  <= item;
          res     <= '0;
          b_level <= '0;
          b_node  <= '0;
        end
      end
      S_LOAD: begin
        res.status <= (node_ok && next_ok) ? STATUS_OK : STATUS_RANGE;
      end
      S_BUILD_RD1: begin
        b_sum <= sum_rd;
      end
      S_BUILD_WR: begin
        if (build_last_node) begin
          b_node  <= '0;
          b_level <= b_level + LEVEL_BITS'(1);
        end else begin
          b_node <= b_node + NODE_BITS'(1);
        end
      end
      S_QUERY: begin
        cur     <= item_q.node;
        acc     <= '0;
        q_level <= '0;
        if (!node_ok) begin
          res.status <= STATUS_RANGE;
        end else if (steps_over) begin
          res.status <= STATUS_STEPS;
        end
      end
      S_QSTEP: begin
        if (q_done) begin
          res.end_node <= cur;
          res.total    <= acc;
        end else if (!q_bit) begin
          q_level <= q_level + LEVEL_BITS'(1);
        end
      end
      S_QACC: begin
        acc     <= acc + sum_rd;
        cur     <= jump_rd;
        q_level <= q_level + LEVEL_BITS'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_RESP && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && out_free) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire

// ----- src/blws_checker.sv -----
// ----------------------------------------------------------------------------
// blws_checker
// Port-level checks for the binary-lifting walk-sum engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blws_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 cfg_write,
  input wire logic [blws_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input wire logic [blws_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input wire logic                                 item_valid,
  input wire logic                                 item_stall,
  input wire blws_pkg::item_t                      item,
  input wire logic                                 result_valid,
  input wire logic                                 result_stall,
  input wire blws_pkg::result_t                    result
);
  import blws_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("Stalled result changed or dropped.");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("Block took a new transfer before finishing the current item.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.status == STATUS_OK || result.status == STATUS_STEPS
                     || result.status == STATUS_RANGE)
    else $error("Result carries an undefined status.");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != STATUS_OK |-> result.end_node == '0
                                                  && result.total == '0)
    else $error("Failed item returned a nonzero node or total.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("Result valid after reset.");

endmodule

bind binary_lifting_walk_sum blws_checker u_blws_checker (.*);

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary-lifting walk-sum engine. A tracker class
// keeps its own jump and sum tables, predicts the result of every item as it
// is transferred in, and compares each result transfer field by field. Every
// phase sets both registers, loads every node in use, builds, and then mixes
// queries, reloads, rebuilds and no-ops; both sides idle at random, bar the last.
// ----------------------------------------------------------------------------

module tb_top;
  import blws_pkg::*;

  localparam logic [ACTION_BITS-1:0]    ACT_NOP   = 2'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;

  class walk_tracker;
    logic [NODE_BITS-1:0] jump_mem [LEVELS][MAX_NODES];
    logic [SUM_BITS-1:0]  sum_mem  [LEVELS][MAX_NODES];
    int unsigned          node_count;
    int unsigned          level_count;
    result_t              awaited[$];
    int                   errors;

    function new();
      node_count  = MAX_NODES;
      level_count = LEVELS;
      errors      = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_BITS-1:0] index,
                          logic [CFG_DATA_BITS-1:0] data);
      int unsigned v;
      if (index == CFG_NODE_COUNT) begin
        v = data;
        node_count = (v < 1) ? 1 : (v > MAX_NODES) ? MAX_NODES : v;
      end else if (index == CFG_LEVEL_COUNT) begin
        v = data[LEVEL_BITS-1:0];
        level_count = (v < 1) ? 1 : (v > LEVELS) ? LEVELS : v;
      end
    endfunction

    function void double_levels();
      int unsigned mid;
      for (int k = 0; k + 1 < level_count; k++) begin
        for (int i = 0; i < node_count; i++) begin
          mid = jump_mem[k][i];
          jump_mem[k+1][i] = jump_mem[k][mid];
          sum_mem[k+1][i]  = sum_mem[k][i] + sum_mem[k][mid];
        end
      end
    endfunction

    function result_t outcome_of(item_t it);
      result_t              r;
      logic [NODE_BITS-1:0] here;
      logic [SUM_BITS-1:0]  accum;
      r = '0;
      case (it.action)
        ACT_LOAD: begin
          if (it.node >= node_count || it.next_node >= node_count) begin
            r.status = STATUS_RANGE;
          end else begin
            jump_mem[0][it.node] = it.next_node;
            sum_mem[0][it.node] =
              {{(SUM_BITS - WEIGHT_BITS){it.weight[WEIGHT_BITS-1]}}, it.weight};
          end
        end
        ACT_BUILD: double_levels();
        ACT_QUERY: begin
          if (it.node >= node_count) begin
            r.status = STATUS_RANGE;
          end else if ((it.steps >> level_count) != 0) begin
            r.status = STATUS_STEPS;
          end else begin
            here  = it.node;
            accum = '0;
            for (int k = 0; k < level_count; k++) begin
              if (it.steps[k]) begin
                accum = accum + sum_mem[k][here];
                here  = jump_mem[k][here];
              end
            end
            r.end_node = here;
            r.total    = accum;
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_transfer(item_t it);
      awaited.push_back(outcome_of(it));
    endfunction

    function void check_transfer(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        $error("result transfer with no item pending: end_node %0d total %0d status %0d",
               got.end_node, got.total, got.status);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.end_node !== want.end_node) begin
        $error("end_node mismatch: expected %0d, actual %0d", want.end_node, got.end_node);
        errors++;
      end
      if (got.total !== want.total) begin
        $error("total mismatch: expected %0d, actual %0d", want.total, got.total);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      cfg_write    = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;
  logic                      item_valid   = 1'b0;
  item_t                     item         = '0;
  logic                      result_stall = 1'b0;
  logic                      item_stall;
  logic                      result_valid;
  result_t                   result;

  bit          calm        = 1'b0;
  bit          hold_armed  = 1'b0;
  bit          hold_output = 1'b0;
  walk_tracker board       = new();

  binary_lifting_walk_sum uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) board.check_transfer(result);
  end

  initial begin : output_side
    forever begin
      @(negedge clk);
      if (hold_output) begin
        result_stall <= 1'b1;
        repeat (300) @(negedge clk);
        hold_output = 1'b0;
        result_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  function automatic logic [WEIGHT_BITS-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0: return WEIGHT_BITS'(1) << (WEIGHT_BITS - 1);
      1: return ~(WEIGHT_BITS'(1) << (WEIGHT_BITS - 1));
      2: return '1;
      3: return '0;
      default: return WEIGHT_BITS'($urandom);
    endcase
  endfunction

  function automatic item_t item_of(logic [ACTION_BITS-1:0] action, int unsigned node,
                                    int unsigned next, logic [WEIGHT_BITS-1:0] weight,
                                    logic [STEP_BITS-1:0] steps);
    item_t it;
    it.action    = action;
    it.node      = NODE_BITS'(node);
    it.next_node = NODE_BITS'(next);
    it.weight    = weight;
    it.steps     = steps;
    return it;
  endfunction

  // Queries only walk tables that are fully loaded and built; before that a
  // query at a node in use carries either no steps or too many.
  function automatic item_t random_item(int unsigned n, int unsigned l, bit ready);
    item_t                it;
    int unsigned          pick;
    logic [STEP_BITS-1:0] span;
    it.action    = ACT_NOP;
    it.node      = NODE_BITS'($urandom);
    it.next_node = NODE_BITS'($urandom);
    it.weight    = pick_weight();
    it.steps     = STEP_BITS'({$urandom, $urandom});
    span         = (STEP_BITS'(1) << l) - 1'b1;
    pick         = $urandom_range(0, 99);
    if (pick < 68) begin
      it.action = ACT_QUERY;
      if ($urandom_range(0, 6) != 0) it.node = NODE_BITS'($urandom_range(0, n - 1));
      case ($urandom_range(0, 3))
        0: it.steps = it.steps & STEP_BITS'({$urandom, $urandom})
                               & STEP_BITS'({$urandom, $urandom});
        1: it.steps = '1;
        default: ;
      endcase
      it.steps &= span;
      if (!ready) it.steps = '0;
      if (l < STEP_BITS && $urandom_range(0, 6) == 0)
        it.steps[$urandom_range(l, STEP_BITS - 1)] = 1'b1;
    end else if (pick < 88) begin
      it.action = ACT_LOAD;
      if ($urandom_range(0, 9) != 0) begin
        it.node      = NODE_BITS'($urandom_range(0, n - 1));
        it.next_node = NODE_BITS'($urandom_range(0, n - 1));
      end
    end else if (pick < 89 && ready) begin
      it.action = ACT_BUILD;
    end
    return it;
  endfunction

  // Called just after a falling edge; returns just after a falling edge with
  // valid still high unless an idle burst followed the transfer.
  task automatic push_item(input item_t it);
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    board.note_transfer(it);
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (board.awaited.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    board.set_reg(index, data);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_BITS-1:0] node_raw,
                           input logic [LEVEL_BITS-1:0] level_raw);
    wait_idle();
    write_reg(CFG_NODE_COUNT, node_raw);
    write_reg(CFG_LEVEL_COUNT,
              {(CFG_DATA_BITS - LEVEL_BITS)'($urandom), level_raw});
  endtask

  task automatic run_phase(input logic [CFG_DATA_BITS-1:0] node_raw,
                           input logic [LEVEL_BITS-1:0] level_raw,
                           input int unsigned count);
    int unsigned n;
    int unsigned l;
    configure(node_raw, level_raw);
    n = board.node_count;
    l = board.level_count;
    repeat (4) push_item(random_item(n, l, 1'b0));
    for (int i = 0; i < n; i++)
      push_item(item_of(ACT_LOAD, i, $urandom_range(0, n - 1), pick_weight(), '0));
    push_item(item_of(ACT_BUILD, $urandom, $urandom, $urandom, '0));
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_idle();
      if (i == 10 && hold_armed) begin
        hold_armed  = 1'b0;
        hold_output = 1'b1;
      end
      push_item(random_item(n, l, 1'b1));
    end
  endtask

  initial begin : main_flow
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_item(item_of(ACT_QUERY, 0, 0, '0, '0));
    push_item(item_of(ACT_QUERY, MAX_NODES - 1, 0, '0, '0));
    push_item(item_of(ACT_NOP, MAX_NODES - 1, MAX_NODES - 1, '1, '1));

    configure(CFG_DATA_BITS'(4), LEVEL_BITS'(3));
    write_reg(CFG_SPARE, CFG_DATA_BITS'($urandom));
    push_item(item_of(ACT_QUERY, 4, 0, '0, '0));
    push_item(item_of(ACT_QUERY, MAX_NODES - 1, 0, '0, STEP_BITS'(8)));
    push_item(item_of(ACT_QUERY, 2, 0, '0, STEP_BITS'(8)));
    push_item(item_of(ACT_QUERY, 0, 0, '0, '1));
    push_item(item_of(ACT_LOAD, 4, 0, '1, '0));
    push_item(item_of(ACT_LOAD, 0, 4, '1, '0));
    push_item(item_of(ACT_LOAD, 0, 1, 32'h8000_0000, '0));
    push_item(item_of(ACT_LOAD, 1, 2, 32'h7fff_ffff, '0));
    push_item(item_of(ACT_LOAD, 2, 3, '1, '0));
    push_item(item_of(ACT_LOAD, 3, 0, '0, '0));
    push_item(item_of(ACT_BUILD, 0, 0, '0, '0));
    push_item(item_of(ACT_QUERY, 0, 0, '0, STEP_BITS'(7)));
    push_item(item_of(ACT_QUERY, 3, 0, '0, STEP_BITS'(5)));
    push_item(item_of(ACT_QUERY, 1, 0, '0, STEP_BITS'(1)));
    push_item(item_of(ACT_QUERY, 2, 0, '0, '0));

    configure(CFG_DATA_BITS'(2), LEVEL_BITS'(63));
    push_item(item_of(ACT_LOAD, 0, 1, 32'h7fff_ffff, '0));
    push_item(item_of(ACT_LOAD, 1, 1, 32'h7fff_ffff, '0));
    push_item(item_of(ACT_BUILD, 0, 0, '0, '0));
    push_item(item_of(ACT_QUERY, 0, 0, '0, '1));
    push_item(item_of(ACT_QUERY, 1, 0, '0, STEP_BITS'(1) << (STEP_BITS - 1)));

    configure('0, '0);
    push_item(item_of(ACT_LOAD, 0, 0, 32'h8000_0000, '0));
    push_item(item_of(ACT_BUILD, 0, 0, '0, '0));
    push_item(item_of(ACT_QUERY, 0, 0, '0, STEP_BITS'(1)));
    push_item(item_of(ACT_QUERY, 0, 0, '0, STEP_BITS'(2)));

    run_phase('1, LEVEL_BITS'(2), 100);
    hold_armed = 1'b1;
    run_phase(CFG_DATA_BITS'(2), LEVEL_BITS'(60), 100);
    run_phase(CFG_DATA_BITS'(1), LEVEL_BITS'(1), 60);
    run_phase(CFG_DATA_BITS'(3), LEVEL_BITS'(61), 100);
    for (int p = 0; p < 8; p++) begin
      if (p == 7) calm = 1'b1;
      run_phase(($urandom_range(0, 9) == 0) ? '0 : CFG_DATA_BITS'($urandom_range(1, 32)),
                LEVEL_BITS'($urandom_range(0, 63)), 50);
    end

    wait_idle();
    repeat (150) @(negedge clk);
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
